### rtl/wtsp_pkg.sv
// Shared constants and types for the world-to-screen projection block.
package wtsp_pkg;

    localparam int COORD_W           = 32;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 4;
    localparam int SCREEN_W          = 14;
    localparam int DEF_FRACTION_BITS = 16;
    // Quotient bits resolved by the divider and the clamp exponent of the scaled term.
    localparam int DIV_QBITS         = 42;
    localparam int TERM_EXP          = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_FIRST  = 4'd0,
        CFG_ROW0_SECOND = 4'd1,
        CFG_ROW1_FIRST  = 4'd2,
        CFG_ROW1_SECOND = 4'd3,
        CFG_ROW3_FIRST  = 4'd4,
        CFG_ROW3_SECOND = 4'd5,
        CFG_WIDTH       = 4'd6,
        CFG_HEIGHT      = 4'd7
    } t_cfg_idx;

endpackage

### rtl/world_to_screen_projection_top.sv
// Top level of the world-to-screen projection pipeline.
// Takes one world point per cycle while the output is not stalled and gives one result per
// point in the same order. It passes through the matrix products and sums, the visibility
// test and the screen-size scaling, the bit-per-stage divider by depth, and the output
// register. A stall at the output holds the whole pipeline.
// The configuration port is always ready; matrix rows and screen size must only be written
// while no point is in flight.
module world_to_screen_projection_top import wtsp_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [3*COORD_W-1:0]    i_s_tdata,   // world_x, world_y, world_z
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [2*COORD_W-1:0]    o_m_tdata,   // pixel_x, pixel_y
    output logic                    o_m_tuser,   // visible
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DW  = 67 - FRACTION_BITS;
    localparam int PW  = DW + SCREEN_W - 1;
    localparam int QB  = DIV_QBITS;
    localparam int SW  = TERM_EXP + SCREEN_W + 2;
    localparam int ONE = 2 ** FRACTION_BITS;
    localparam int THR = ONE / 100 + (((ONE % 100) >= 50) ? 1 : 0);

    logic [CFG_DATA_W-1:0] r_row0_a, r_row0_b, r_row1_a, r_row1_b, r_row3_a, r_row3_b;
    logic [SCREEN_W-1:0]   r_width, r_height;

    logic w_en;
    logic signed [COORD_W-1:0] w_x, w_y, w_z;
    logic signed [DW-1:0] w_n0, w_n1, w_depth;

    logic r1_valid, r2_valid, r3_valid;
    logic r3_vis, r3_sx, r3_sy;
    logic [PW-1:0] r3_px, r3_py;
    logic [DW-1:0] r3_den;

    logic r_sv [0:QB];
    logic r_svis [0:QB];
    logic r_ssx [0:QB];
    logic r_ssy [0:QB];

    logic [QB-1:0] w_qx, w_qy;
    logic          w_ovfx, w_ovfy;

    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_out_px, r_out_py;
    logic                 r_out_vis;

    logic                  w_vis;
    logic [DW-2:0]         w_mag0, w_mag1;
    logic [QB-1:0]         w_limx, w_limy;
    logic signed [SW-1:0]  w_tx, w_ty, w_kx, w_ky, w_half, w_pxf, w_pyf;
    logic [COORD_W-1:0]    n_out_px, n_out_py;

    assign w_en        = !r_out_valid || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    assign w_x = $signed(i_s_tdata[COORD_W-1:0]);
    assign w_y = $signed(i_s_tdata[2*COORD_W-1:COORD_W]);
    assign w_z = $signed(i_s_tdata[3*COORD_W-1:2*COORD_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_a <= '0;
            r_row0_b <= '0;
            r_row1_a <= '0;
            r_row1_b <= '0;
            r_row3_a <= '0;
            r_row3_b <= '0;
            r_width  <= SCREEN_W'(1920);
            r_height <= SCREEN_W'(1080);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW0_FIRST:  r_row0_a <= i_cfg_data;
                CFG_ROW0_SECOND: r_row0_b <= i_cfg_data;
                CFG_ROW1_FIRST:  r_row1_a <= i_cfg_data;
                CFG_ROW1_SECOND: r_row1_b <= i_cfg_data;
                CFG_ROW3_FIRST:  r_row3_a <= i_cfg_data;
                CFG_ROW3_SECOND: r_row3_b <= i_cfg_data;
                CFG_WIDTH:       r_width  <= i_cfg_data[SCREEN_W-1:0];
                CFG_HEIGHT:      r_height <= i_cfg_data[SCREEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wtsp_dot #(.FRACTION_BITS(FRACTION_BITS), .DW(DW)) u_dot0 (
        .i_clk(i_clk), .i_en(w_en), .i_first(r_row0_a), .i_second(r_row0_b),
        .i_x(w_x), .i_y(w_y), .i_z(w_z), .o_dot(w_n0)
    );
    wtsp_dot #(.FRACTION_BITS(FRACTION_BITS), .DW(DW)) u_dot1 (
        .i_clk(i_clk), .i_en(w_en), .i_first(r_row1_a), .i_second(r_row1_b),
        .i_x(w_x), .i_y(w_y), .i_z(w_z), .o_dot(w_n1)
    );
    wtsp_dot #(.FRACTION_BITS(FRACTION_BITS), .DW(DW)) u_dot3 (
        .i_clk(i_clk), .i_en(w_en), .i_first(r_row3_a), .i_second(r_row3_b),
        .i_x(w_x), .i_y(w_y), .i_z(w_z), .o_dot(w_depth)
    );

    always_comb begin
        w_vis  = (w_depth >= DW'(THR)) && (w_depth > 0);
        w_mag0 = w_n0[DW-1] ? (DW-1)'(-w_n0) : w_n0[DW-2:0];
        w_mag1 = w_n1[DW-1] ? (DW-1)'(-w_n1) : w_n1[DW-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i <= QB; i++) begin
                r_sv[i] <= 1'b0;
            end
        end else if (w_en) begin
            r1_valid    <= i_s_tvalid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_sv[0]     <= r3_valid;
            for (int i = 1; i <= QB; i++) begin
                r_sv[i] <= r_sv[i-1];
            end
            r_out_valid <= r_sv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_vis    <= w_vis;
            r3_sx     <= w_n0[DW-1];
            r3_sy     <= w_n1[DW-1];
            r3_px     <= PW'(w_mag0) * PW'(r_width);
            r3_py     <= PW'(w_mag1) * PW'(r_height);
            r3_den    <= w_depth;
            r_svis[0] <= r3_vis;
            r_ssx[0]  <= r3_sx;
            r_ssy[0]  <= r3_sy;
            for (int i = 1; i <= QB; i++) begin
                r_svis[i] <= r_svis[i-1];
                r_ssx[i]  <= r_ssx[i-1];
                r_ssy[i]  <= r_ssy[i-1];
            end
            r_out_vis <= r_svis[QB];
            r_out_px  <= n_out_px;
            r_out_py  <= n_out_py;
        end
    end

    wtsp_div #(.FRACTION_BITS(FRACTION_BITS), .DW(DW), .PW(PW)) u_divx (
        .i_clk(i_clk), .i_en(w_en), .i_prod(r3_px), .i_den(r3_den),
        .o_quo(w_qx), .o_ovf(w_ovfx)
    );
    wtsp_div #(.FRACTION_BITS(FRACTION_BITS), .DW(DW), .PW(PW)) u_divy (
        .i_clk(i_clk), .i_en(w_en), .i_prod(r3_py), .i_den(r3_den),
        .o_quo(w_qy), .o_ovf(w_ovfy)
    );

    // Quotients beyond the clamp are replaced by the clamp; this never changes the saturated
    // pixel value.
    always_comb begin
        w_limx = (w_ovfx || w_qx > (QB'(1) << TERM_EXP)) ? (QB'(1) << TERM_EXP) : w_qx;
        w_limy = (w_ovfy || w_qy > (QB'(1) << TERM_EXP)) ? (QB'(1) << TERM_EXP) : w_qy;
        w_tx   = r_ssx[QB] ? -SW'(w_limx) : SW'(w_limx);
        w_ty   = r_ssy[QB] ? -SW'(w_limy) : SW'(w_limy);
        w_kx   = SW'(r_width) << (FRACTION_BITS - 1);
        w_ky   = SW'(r_height) << (FRACTION_BITS - 1);
        w_half = SW'(1) << (FRACTION_BITS - 1);
        w_pxf  = w_kx + (w_tx + w_half);
        w_pyf  = w_ky - (w_ty + w_half);
        if (w_pxf[SW-1:COORD_W-1] == '0 || w_pxf[SW-1:COORD_W-1] == '1) begin
            n_out_px = w_pxf[COORD_W-1:0];
        end else begin
            n_out_px = w_pxf[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (w_pyf[SW-1:COORD_W-1] == '0 || w_pyf[SW-1:COORD_W-1] == '1) begin
            n_out_py = w_pyf[COORD_W-1:0];
        end else begin
            n_out_py = w_pyf[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (!r_svis[QB]) begin
            n_out_px = '0;
            n_out_py = '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_vis;
    assign o_m_tdata  = {r_out_py, r_out_px};

`ifndef SYNTHESIS
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("hidden point with nonzero coordinates");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_sv[QB]))
        else $error("output word without a word in the last divider stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !r1_valid && !r3_valid))
        else $error("pipeline not empty after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> (r_sv[QB] == $past(r_sv[QB]) && r3_valid == $past(r3_valid)))
        else $error("pipeline moved during a stall");
`endif

endmodule

### rtl/wtsp_dot.sv
// Two-stage dot product of one matrix row with (x, y, z, 1).
module wtsp_dot import wtsp_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int DW            = 67 - FRACTION_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [CFG_DATA_W-1:0]      i_first,
    input  logic [CFG_DATA_W-1:0]      i_second,
    input  logic signed [COORD_W-1:0]  i_x,
    input  logic signed [COORD_W-1:0]  i_y,
    input  logic signed [COORD_W-1:0]  i_z,
    output logic signed [DW-1:0]       o_dot
);

    logic signed [2*COORD_W-1:0] r_p0, r_p1, r_p2;
    logic signed [COORD_W-1:0]   r_c3;
    logic signed [DW-1:0]        r_dot;
    logic signed [DW-1:0]        n_dot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= $signed(i_first[COORD_W-1:0]) * i_x;
            r_p1  <= $signed(i_first[2*COORD_W-1:COORD_W]) * i_y;
            r_p2  <= $signed(i_second[COORD_W-1:0]) * i_z;
            r_c3  <= $signed(i_second[2*COORD_W-1:COORD_W]);
            r_dot <= n_dot;
        end
    end

    // Each product is floored to the fixed-point grid before the sum.
    always_comb begin
        n_dot = DW'(r_p0 >>> FRACTION_BITS) + DW'(r_p1 >>> FRACTION_BITS)
              + DW'(r_p2 >>> FRACTION_BITS) + DW'(r_c3);
    end

    assign o_dot = r_dot;

endmodule

### rtl/wtsp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module wtsp_div import wtsp_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int DW            = 67 - FRACTION_BITS,
    parameter int PW            = DW + SCREEN_W - 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [PW-1:0]        i_prod,
    input  logic [DW-1:0]        i_den,
    output logic [DIV_QBITS-1:0] o_quo,
    output logic                 o_ovf
);

    localparam int QB = DIV_QBITS;
    localparam int NW = PW + FRACTION_BITS - 1;

    logic [NW-1:0] w_num;
    logic [NW-1:0] w_hi;
    logic          w_ovf;

    logic [DW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_low [0:QB];
    logic [QB-1:0] r_quo [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic          r_ovf [0:QB];

    // The dividend is the product scaled by half of one unit.
    always_comb begin
        w_num = {i_prod, {(FRACTION_BITS-1){1'b0}}};
        w_hi  = w_num >> QB;
        w_ovf = w_hi >= NW'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_ovf ? '0 : DW'(w_hi);
            r_low[0] <= w_num[QB-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= w_ovf;
        end
    end

    for (genvar g = 1; g <= QB; g++) begin : g_step
        logic [DW:0] w_trial;
        logic        w_ge;

        always_comb begin
            w_trial = {r_rem[g-1], r_low[g-1][QB-1]};
            w_ge    = w_trial >= {1'b0, r_den[g-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_ge ? DW'(w_trial - {1'b0, r_den[g-1]}) : DW'(w_trial);
                r_low[g] <= {r_low[g-1][QB-2:0], 1'b0};
                r_quo[g] <= {r_quo[g-1][QB-2:0], w_ge};
                r_den[g] <= r_den[g-1];
                r_ovf[g] <= r_ovf[g-1];
            end
        end
    end

    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];

endmodule

### verif/world_to_screen_projection_top_test.sv
// Self-checking testbench for the world-to-screen projection pipeline.
`timescale 1ns / 1ps

module world_to_screen_projection_top_test;
    import wtsp_pkg::*;

    localparam int FB = DEF_FRACTION_BITS;
    localparam int DRAIN_CYCLES = DIV_QBITS + 20;
    localparam int STALL_LIMIT = 5000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BEYOND = 4'd12;

    typedef struct {
        logic        visible;
        logic [31:0] pixel_x;
        logic [31:0] pixel_y;
    } t_screen_pt;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [3*COORD_W-1:0]   i_s_tdata;   // world_x, world_y, world_z
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [2*COORD_W-1:0]   o_m_tdata;   // pixel_x, pixel_y
    logic                   o_m_tuser;   // visible
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    world_to_screen_projection_top dut (.*);

    // Shadow copy of the block's registers.
    logic [63:0] row0_a, row0_b, row1_a, row1_b, row3_a, row3_b;
    logic [13:0] scr_w, scr_h;

    t_screen_pt expected_pts[$];
    int errors;
    int send_idle;
    int recv_stall;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint row_dot(logic [63:0] a, logic [63:0] b,
                                       logic [31:0] x, logic [31:0] y, logic [31:0] z);
        longint acc;
        acc = (longint'($signed(a[31:0])) * longint'($signed(x))) >>> FB;
        acc += (longint'($signed(a[63:32])) * longint'($signed(y))) >>> FB;
        acc += (longint'($signed(b[31:0])) * longint'($signed(z))) >>> FB;
        acc += longint'($signed(b[63:32]));
        return acc;
    endfunction

    // num * k / d truncated toward zero, clamped to +-2^40.
    function automatic longint scaled_term(longint num, logic [63:0] k, logic [63:0] d);
        logic [63:0]  mag;
        logic [127:0] q;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        q = ({64'b0, mag} * {64'b0, k}) / {64'b0, d};
        if (q > (128'd1 << TERM_EXP))
            q = 128'd1 << TERM_EXP;
        return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_screen_pt project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_screen_pt r;
        longint depth, thr, half, n0, n1, kx, ky;
        depth = row_dot(row3_a, row3_b, x, y, z);
        thr = ((64'sd1 << FB) / 100) + ((((64'sd1 << FB) % 100) >= 50) ? 1 : 0);
        half = 64'sd1 << (FB - 1);
        r = '{1'b0, 32'd0, 32'd0};
        if (depth < thr || depth <= 0)
            return r;
        n0 = row_dot(row0_a, row0_b, x, y, z);
        n1 = row_dot(row1_a, row1_b, x, y, z);
        kx = longint'(scr_w) << (FB - 1);
        ky = longint'(scr_h) << (FB - 1);
        r.visible = 1'b1;
        r.pixel_x = sat32(kx + (scaled_term(n0, kx, depth) + half));
        r.pixel_y = sat32(ky - (scaled_term(n1, ky, depth) + half));
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_screen_pt e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_pts.size() == 0) begin
                report_mismatch("unexpected word", o_m_tdata[31:0], 32'd0);
            end else begin
                e = expected_pts.pop_front();
                if (o_m_tuser !== e.visible)
                    report_mismatch("visible", {31'd0, o_m_tuser}, {31'd0, e.visible});
                if (o_m_tdata[31:0] !== e.pixel_x)
                    report_mismatch("pixel_x", o_m_tdata[31:0], e.pixel_x);
                if (o_m_tdata[63:32] !== e.pixel_y)
                    report_mismatch("pixel_y", o_m_tdata[63:32], e.pixel_y);
            end
        end
    end

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall);

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid stays high between back-to-back words; it is dropped by idle cycles or drain.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(0, 99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        expected_pts.push_back(project(x, y, z));
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_pts.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW0_FIRST:  row0_a = data;
            CFG_ROW0_SECOND: row0_b = data;
            CFG_ROW1_FIRST:  row1_a = data;
            CFG_ROW1_SECOND: row1_b = data;
            CFG_ROW3_FIRST:  row3_a = data;
            CFG_ROW3_SECOND: row3_b = data;
            CFG_WIDTH:       scr_w = data[13:0];
            CFG_HEIGHT:      scr_h = data[13:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            2: return 32'd0;
            default: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
    endfunction

    function automatic logic [63:0] rand_size();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v[13:0] = 14'd1;
            1: v[13:0] = 14'd8192;
            2: v[13:0] = 14'd0;
            3: v[13:0] = 14'h3FFF;
            default: v[13:0] = 14'($urandom_range(1, 8192));
        endcase
        return v;
    endfunction

    task automatic test_reset_values();
        // All-zero matrix after reset: depth is zero, nothing is visible.
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_point($urandom, $urandom, $urandom);
        drain();
    endtask

    task automatic test_directed();
        write_reg(CFG_ROW3_FIRST, 64'd0);
        write_reg(CFG_ROW3_SECOND, {32'd0, 32'h0001_0000});  // depth = z
        write_reg(CFG_ROW0_FIRST, {32'd0, 32'h0001_0000});
        write_reg(CFG_ROW1_FIRST, {32'h0001_0000, 32'd0});
        write_reg(CFG_ROW0_SECOND, 64'd0);
        write_reg(CFG_ROW1_SECOND, 64'd0);
        send_point(32'd0, 32'd0, 32'd654);              // just below the threshold
        send_point(32'd0, 32'd0, 32'd655);              // exactly at the threshold
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd655);  // saturates
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd700);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0004_0000, 32'h0002_0000, 32'h0002_0000);
        write_reg(CFG_WIDTH, 64'd1);
        write_reg(CFG_HEIGHT, 64'd8192);
        send_point(32'h0004_0000, 32'hFFFE_0000, 32'h0002_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000);
        // A zero screen size gives no center and no scale.
        write_reg(CFG_WIDTH, 64'd0);
        write_reg(CFG_HEIGHT, 64'h3FFF);
        send_point(32'h0004_0000, 32'h0002_0000, 32'h0002_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        // An index past the register list changes nothing.
        write_reg(CFG_IDX_BEYOND, {$urandom, $urandom});
        send_point(32'h0004_0000, 32'h0002_0000, 32'h0002_0000);
        write_reg(CFG_WIDTH, 64'd8192);
        write_reg(CFG_HEIGHT, 64'd1);
        send_point(32'hFFFC_0000, 32'h0003_0000, 32'h0001_8000);
        drain();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct);
        logic [31:0] dz, dc;
        send_idle = idle_pct;
        recv_stall = stall_pct;
        for (int s = 0; s < 5; s++) begin
            write_reg(CFG_ROW0_FIRST, {rand_coef(), rand_coef()});
            write_reg(CFG_ROW0_SECOND, {rand_coef(), rand_coef()});
            write_reg(CFG_ROW1_FIRST, {rand_coef(), rand_coef()});
            write_reg(CFG_ROW1_SECOND, {rand_coef(), rand_coef()});
            // Depth row mostly leans on z with a positive bias so that many points are visible.
            dz = $urandom_range(0, 3) == 0 ? rand_coef() : $urandom_range(1 << 12, 1 << 18);
            dc = $urandom_range(0, 3) == 0 ? rand_coef() : $urandom_range(0, 1 << 22);
            write_reg(CFG_ROW3_FIRST, {rand_coef() >>> 4, rand_coef() >>> 4});
            write_reg(CFG_ROW3_SECOND, {dc, dz});
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_BEYOND + 4'($urandom_range(0, 3)), {$urandom, $urandom});
            write_reg(CFG_WIDTH, rand_size());
            write_reg(CFG_HEIGHT, rand_size());
            for (int n = 0; n < 70; n++)
                send_point(rand_coord(), rand_coord(), rand_coord());
        end
        drain();
    endtask

    initial begin
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        row0_a = '0; row0_b = '0; row1_a = '0; row1_b = '0; row3_a = '0; row3_b = '0;
        scr_w = 14'd1920;
        scr_h = 14'd1080;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed();
        test_random_phase(0, 0);
        test_random_phase(51, 0);
        test_random_phase(0, 51);
        test_random_phase(10, 10);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
